[rtl/skwf_pkg.sv]
// Package: shared types, constants and float compare helpers for the key window filter.
`default_nettype none
package skwf_pkg;
	localparam logic [7:0] MAGIC_POINT = 8'hE5;
	localparam logic [7:0] MAGIC_SEGMENT = 8'hE6;
	localparam logic [11:0] FOOTER_BYTES = 12'd8;
	localparam logic [11:0] POINT_MIN_LEN = 12'd13;
	localparam logic [11:0] SEGMENT_MIN_LEN = 12'd25;
	localparam int NUM_REGS = 6;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_TIME_LOW = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TIME_HIGH = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_X_LOW = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_X_HIGH = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_Y_LOW = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_Y_HIGH = 3'd5;

	typedef struct packed {
		logic [11:0] key_length;
		logic [7:0]  key_magic;
		logic [31:0] word_a;
		logic [31:0] word_b;
		logic [31:0] word_c;
		logic [31:0] word_d;
		logic [31:0] word_e;
		logic [31:0] word_f;
	} key_word_t;

	typedef struct packed {
		logic        in_window;
		logic [47:0] passed_count;
		logic [47:0] seen_count;
	} result_word_t;

	typedef struct packed {
		logic [31:0] time_low;
		logic [31:0] time_high;
		logic [31:0] x_low;
		logic [31:0] x_high;
		logic [31:0] y_low;
		logic [31:0] y_high;
	} window_t;

	// Queue entry: classified key flags
	typedef struct packed {
		logic in_window;
	} verdict_t;

	function automatic logic is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	// IEEE single a > b, false on NaN, -0 equals +0
	function automatic logic f_gt(input logic [31:0] a, input logic [31:0] b);
		logic both_zero;
		both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
		if (is_nan(a) || is_nan(b) || both_zero)
			return 1'b0;
		if (a[31] != b[31])
			return b[31];
		if (!a[31])
			return a[30:0] > b[30:0];
		return a[30:0] < b[30:0];
	endfunction
endpackage
`default_nettype wire

[rtl/skwf_if.sv]
// Interface: valid/ready channel carrying one word of a given type.
`default_nettype none
interface skwf_if #(parameter type word_t = logic) ();
	logic  valid;
	logic  ready;
	word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/spatiotemporal_key_window_filter.sv]
// Top level: spatio-temporal key window filter.
// channel | dir | handshake          | word
// key     | in  | key.valid/ready    | key_word_t
// result  | out | result.valid/ready | result_word_t
// cfg     | in  | cfg_we             | cfg_index, cfg_data
// One key per cycle sustained while results are taken; an accepted key's verdict is written
// into the queue, then into the output register, before its result is presented.
// Classification is combinational at the input, counting is in the back part.
// A two-entry queue lets the key side keep going while a result is stalled.
// Reset clears window registers and counters to zero.
`default_nettype none
module spatiotemporal_key_window_filter
	import skwf_pkg::*;
#(
	parameter int COUNT_WIDTH = 48
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	skwf_if.sink                      key,
	skwf_if.source                    result,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);
	window_t  win_q;
	verdict_t verdict, head;
	logic     full, nonempty, take, push;

	// Window register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIME_LOW:  win_q.time_low <= cfg_data;
				REG_TIME_HIGH: win_q.time_high <= cfg_data;
				REG_X_LOW:     win_q.x_low <= cfg_data;
				REG_X_HIGH:    win_q.x_high <= cfg_data;
				REG_Y_LOW:     win_q.y_low <= cfg_data;
				REG_Y_HIGH:    win_q.y_high <= cfg_data;
				default:       ;
			endcase
		end
	end

	assign key.ready = !full;
	assign push = key.valid && !full;

	skwf_front u_front (
		.key(key.data), .win(win_q), .verdict(verdict)
	);

	skwf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_word(verdict), .full(full),
		.pop(take), .nonempty(nonempty), .head(head)
	);

	skwf_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .avail(nonempty), .verdict(head), .take(take),
		.out_valid(result.valid), .out_ready(result.ready), .out_word(result.data)
	);
endmodule
`default_nettype wire

[rtl/skwf_front.sv]
// Front part: effective length and window classification of each key.
`default_nettype none
module skwf_front
	import skwf_pkg::*;
(
	input  wire key_word_t key,
	input  wire window_t   win,
	output verdict_t       verdict
);
	logic [11:0] stripped, eff_len;
	logic        is_pt, is_seg, pt_ok, seg_ok;

	// Effective length after footer removal
	always_comb begin
		stripped = key.key_length - FOOTER_BYTES;
		is_pt = key.key_magic == MAGIC_POINT;
		is_seg = key.key_magic == MAGIC_SEGMENT;
		if (key.key_length <= FOOTER_BYTES)
			eff_len = '0;
		else if (is_seg && stripped < SEGMENT_MIN_LEN)
			eff_len = key.key_length;
		else if (is_pt && stripped < POINT_MIN_LEN)
			eff_len = key.key_length;
		else
			eff_len = stripped;
	end

	// Point and segment tests
	always_comb begin
		pt_ok = !(key.word_a > win.time_high || key.word_a < win.time_low
			|| f_gt(key.word_b, win.x_high) || f_gt(win.x_low, key.word_b)
			|| f_gt(key.word_c, win.y_high) || f_gt(win.y_low, key.word_c));
		seg_ok = !(key.word_a > win.time_high || key.word_b < win.time_low)
			&& !(f_gt(key.word_c, win.x_high) || f_gt(win.x_low, key.word_e)
			|| f_gt(key.word_d, win.y_high) || f_gt(win.y_low, key.word_f));
		verdict.in_window = (eff_len >= POINT_MIN_LEN)
			&& ((is_pt && pt_ok) || (is_seg && eff_len >= SEGMENT_MIN_LEN && seg_ok));
	end
endmodule
`default_nettype wire

[rtl/skwf_queue.sv]
// Two-entry queue of verdicts between front and back parts.
`default_nettype none
module skwf_queue
	import skwf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire verdict_t push_word,
	output logic          full,
	input  wire logic     pop,
	output logic          nonempty,
	output verdict_t      head
);
	verdict_t    mem_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;

	assign full = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_word;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

[rtl/skwf_back.sv]
// Back part: counters and output register.
`default_nettype none
module skwf_back
	import skwf_pkg::*;
#(
	parameter int COUNT_WIDTH = 48
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     avail,
	input  wire verdict_t verdict,
	output logic          take,
	output logic          out_valid,
	input  wire logic     out_ready,
	output result_word_t  out_word
);
	logic [COUNT_WIDTH-1:0] passed_q, seen_q, passed_nx, seen_nx;
	logic                   valid_q, win_q;

	assign take = avail && (!valid_q || out_ready);
	assign passed_nx = passed_q + COUNT_WIDTH'(verdict.in_window);
	assign seen_nx = seen_q + COUNT_WIDTH'(1);
	assign out_valid = valid_q;

	// Counts are presented at 48 bits
	always_comb begin
		out_word.in_window = win_q;
		out_word.passed_count = 48'(passed_q);
		out_word.seen_count = 48'(seen_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			passed_q <= '0;
			seen_q <= '0;
			win_q <= 1'b0;
		end else begin
			if (take) begin
				valid_q <= 1'b1;
				passed_q <= passed_nx;
				seen_q <= seen_nx;
				win_q <= verdict.in_window;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

[tb/spatiotemporal_key_window_filter_tb.sv]
// Testbench: drives keys through the window filter and checks every result word against a model.
`default_nettype none
module spatiotemporal_key_window_filter_tb;
	import skwf_pkg::*;

	localparam logic [31:0] F_POS_ZERO = 32'h0000_0000;
	localparam logic [31:0] F_NEG_ZERO = 32'h8000_0000;
	localparam logic [31:0] F_ONE      = 32'h3F80_0000;
	localparam logic [31:0] F_M_ONE    = 32'hBF80_0000;
	localparam logic [31:0] F_TEN      = 32'h4120_0000;
	localparam logic [31:0] F_M_TEN    = 32'hC120_0000;
	localparam logic [31:0] F_QNAN     = 32'h7FC0_0000;
	localparam logic [31:0] F_PINF     = 32'h7F80_0000;
	localparam logic [31:0] F_NINF     = 32'hFF80_0000;

	// window predictor: float compare, state and checker in one small class
	class window_scoreboard;
		logic [31:0]  win [NUM_REGS];
		logic [47:0]  passed_total;
		logic [47:0]  seen_total;
		result_word_t pending [$];
		int           mismatches;

		function new();
			foreach (win[i]) win[i] = '0;
			passed_total = '0;
			seen_total = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
			if (idx < NUM_REGS) win[idx] = val;
		endfunction

		// a > b in IEEE single terms
		function bit fgt(logic [31:0] a, logic [31:0] b);
			bit an, bn;
			an = (a[30:23] == 8'hFF) && (a[22:0] != 0);
			bn = (b[30:23] == 8'hFF) && (b[22:0] != 0);
			if (an || bn) return 0;
			if (a[30:0] == 0 && b[30:0] == 0) return 0;
			if (a[31] != b[31]) return b[31];
			if (!a[31]) return a[30:0] > b[30:0];
			return a[30:0] < b[30:0];
		endfunction

		function bit key_passes(key_word_t k);
			logic [11:0] eff;
			if (k.key_length <= FOOTER_BYTES) eff = 0;
			else begin
				eff = k.key_length - FOOTER_BYTES;
				if (k.key_magic == MAGIC_SEGMENT && eff < SEGMENT_MIN_LEN) eff = k.key_length;
				if (k.key_magic == MAGIC_POINT && eff < POINT_MIN_LEN) eff = k.key_length;
			end
			if (eff < POINT_MIN_LEN) return 0;
			if (k.key_magic == MAGIC_POINT)
				return !(k.word_a > win[REG_TIME_HIGH] || k.word_a < win[REG_TIME_LOW] ||
					fgt(k.word_b, win[REG_X_HIGH]) || fgt(win[REG_X_LOW], k.word_b) ||
					fgt(k.word_c, win[REG_Y_HIGH]) || fgt(win[REG_Y_LOW], k.word_c));
			if (k.key_magic == MAGIC_SEGMENT) begin
				if (eff < SEGMENT_MIN_LEN) return 0;
				return !(k.word_a > win[REG_TIME_HIGH] || k.word_b < win[REG_TIME_LOW]) &&
					!(fgt(k.word_c, win[REG_X_HIGH]) || fgt(win[REG_X_LOW], k.word_e) ||
					fgt(k.word_d, win[REG_Y_HIGH]) || fgt(win[REG_Y_LOW], k.word_f));
			end
			return 0;
		endfunction

		function void note_key(key_word_t k);
			result_word_t r;
			r.in_window = key_passes(k);
			seen_total = seen_total + 48'd1;
			if (r.in_window) passed_total = passed_total + 48'd1;
			r.passed_count = passed_total;
			r.seen_count = seen_total;
			pending.push_back(r);
		endfunction

		function void check_result(result_word_t got);
			result_word_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.in_window !== want.in_window || got.passed_count !== want.passed_count ||
					got.seen_count !== want.seen_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: in_window %0b/%0b passed %0d/%0d seen %0d/%0d",
						want.in_window, got.in_window, want.passed_count, got.passed_count,
						want.seen_count, got.seen_count);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	int                   src_idle_pct;
	int                   snk_stall_pct;
	bit                   hold_off;
	window_scoreboard     sb;

	skwf_if #(.word_t(key_word_t))    key_ch ();
	skwf_if #(.word_t(result_word_t)) res_ch ();

	spatiotemporal_key_window_filter dut (
		.clk(clk), .arst_n(arst_n), .key(key_ch.sink), .result(res_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("spatiotemporal_key_window_filter test failed");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
			res_ch.ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
		end
	end

	task automatic write_cfg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_window(logic [31:0] tl, th, xl, xh, yl, yh);
		write_cfg(REG_TIME_LOW, tl);
		write_cfg(REG_TIME_HIGH, th);
		write_cfg(REG_X_LOW, xl);
		write_cfg(REG_X_HIGH, xh);
		write_cfg(REG_Y_LOW, yl);
		write_cfg(REG_Y_HIGH, yh);
	endtask

	// valid stays high after acceptance so keys can go back to back
	task automatic send_key(key_word_t k);
		while ($urandom_range(99) < src_idle_pct) begin
			key_ch.valid <= 0;
			@(posedge clk);
		end
		key_ch.valid <= 1;
		key_ch.data <= k;
		do @(posedge clk); while (!key_ch.ready);
		sb.note_key(k);
	endtask

	task automatic drain();
		key_ch.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_float();
		case ($urandom_range(9))
			0: return F_QNAN | $urandom_range(1) << 31;
			1: return $urandom_range(1) ? F_PINF : F_NINF;
			2: return $urandom_range(1) ? F_POS_ZERO : F_NEG_ZERO;
			3: return $urandom();
			default: return {$urandom_range(1) ? 1'b1 : 1'b0, 8'd127 + 8'($urandom_range(4)) - 8'd2,
				23'($urandom())};
		endcase
	endfunction

	function automatic key_word_t rand_key();
		key_word_t k;
		k = key_word_t'($bits(key_word_t)'({$urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom()}));
		case ($urandom_range(9))
			0: k.key_magic = 8'($urandom());
			1, 2, 3, 4: k.key_magic = MAGIC_POINT;
			default: k.key_magic = MAGIC_SEGMENT;
		endcase
		if ($urandom_range(9) < 7) k.key_length = 12'($urandom_range(40));
		k.word_a = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(200);
		if (k.key_magic == MAGIC_SEGMENT) begin
			k.word_b = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(200);
			k.word_c = pick_float();
		end else begin
			k.word_b = pick_float();
			k.word_c = pick_float();
		end
		k.word_d = pick_float();
		k.word_e = pick_float();
		k.word_f = pick_float();
		return k;
	endfunction

	function automatic key_word_t mk(logic [11:0] len, logic [7:0] mg,
			logic [31:0] a, b, c, d, e, f);
		return '{len, mg, a, b, c, d, e, f};
	endfunction

	initial begin
		sb = new();
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		key_ch.valid = 0;
		key_ch.data = '0;
		res_ch.ready = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		hold_off = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// directed: reset window, then a bounded one
		send_key(mk(12'd0, MAGIC_POINT, 0, 0, 0, 0, 0, 0));
		send_key(mk(12'd4095, MAGIC_POINT, 0, 0, 0, 0, 0, 0));
		drain();
		set_window(32'd10, 32'd100, F_M_TEN, F_TEN, F_M_ONE, F_ONE);
		send_key(mk(12'd8, MAGIC_POINT, 50, F_ONE, 0, 0, 0, 0));
		send_key(mk(12'd9, MAGIC_POINT, 50, F_ONE, 0, 0, 0, 0));
		send_key(mk(12'd12, MAGIC_POINT, 50, F_ONE, 0, 0, 0, 0));
		send_key(mk(12'd13, MAGIC_POINT, 50, F_ONE, 0, 0, 0, 0));
		send_key(mk(12'd21, MAGIC_POINT, 10, F_TEN, F_M_ONE, '1, '1, '1));
		send_key(mk(12'd20, MAGIC_POINT, 101, F_ONE, 0, 0, 0, 0));
		send_key(mk(12'd20, MAGIC_POINT, 9, F_ONE, 0, 0, 0, 0));
		send_key(mk(12'd20, MAGIC_POINT, 50, F_QNAN, F_QNAN, 0, 0, 0));
		send_key(mk(12'd20, MAGIC_POINT, 50, F_PINF, 0, 0, 0, 0));
		send_key(mk(12'd24, MAGIC_SEGMENT, 0, 200, F_M_ONE, F_M_ONE, F_ONE, F_ONE));
		send_key(mk(12'd25, MAGIC_SEGMENT, 0, 200, F_M_ONE, F_M_ONE, F_ONE, F_ONE));
		send_key(mk(12'd33, MAGIC_SEGMENT, 100, 10, F_TEN, F_ONE, F_PINF, F_ONE));
		send_key(mk(12'd33, MAGIC_SEGMENT, 101, 200, 0, 0, 0, 0));
		send_key(mk(12'd33, MAGIC_SEGMENT, 0, 9, 0, 0, 0, 0));
		send_key(mk(12'd40, MAGIC_SEGMENT, 0, 50, F_QNAN, F_QNAN, F_QNAN, F_QNAN));
		send_key(mk(12'd40, 8'h00, 50, F_ONE, 0, 0, 0, 0));
		send_key(mk(12'd40, 8'hFF, 50, F_ONE, 0, 0, 0, 0));
		drain();
		// signed-zero window and extreme time bounds
		set_window(32'd0, '1, F_POS_ZERO, F_NEG_ZERO, F_NEG_ZERO, F_POS_ZERO);
		send_key(mk(12'd21, MAGIC_POINT, '1, F_NEG_ZERO, F_POS_ZERO, 0, 0, 0));
		send_key(mk(12'd21, MAGIC_POINT, 0, F_ONE, F_POS_ZERO, 0, 0, 0));
		send_key(mk(12'd4095, MAGIC_SEGMENT, '1, 0, F_NEG_ZERO, F_POS_ZERO, 0, 0));
		drain();
		write_cfg(3'd7, 32'hDEAD_BEEF);

		// random phases over several windows
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
				default: begin src_idle_pct = 20; snk_stall_pct = 20; end
			endcase
			case (ph)
				0: set_window(32'd20, 32'd150, F_M_TEN, F_TEN, F_M_TEN, F_TEN);
				1: set_window(32'd0, '1, F_NINF, F_PINF, F_NINF, F_PINF);
				2: set_window('1, 32'd0, F_TEN, F_M_TEN, F_ONE, F_M_ONE);
				3: set_window($urandom_range(100), 32'd100 + $urandom_range(100),
					pick_float(), pick_float(), pick_float(), pick_float());
				4: set_window(32'd0, 32'd0, F_QNAN, F_QNAN, F_M_ONE, F_ONE);
				default: set_window($urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom());
			endcase
			if (ph == 2) begin
				// long receiver hold-off while keys keep coming
				fork
					begin
						hold_off = 1;
						repeat (60) @(posedge clk);
						hold_off = 0;
					end
					for (int i = 0; i < 20; i++) send_key(rand_key());
				join
			end
			for (int i = 0; i < 100; i++) begin
				send_key(rand_key());
				if (i == 50) drain();
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("spatiotemporal_key_window_filter test passed");
		else
			$display("spatiotemporal_key_window_filter test failed");
		$finish;
	end
endmodule
`default_nettype wire
